// ----- hw/rtl/tsdl_pkg.sv -----
// ---------------------------------------------------------------------------
// tsdl_pkg: shared types and constants of the traction slip/drop limiter
// Payload structs, register map codes, Q1.15 constants and the control and
// status bundles between the sequencer and the iterative divider.
// ---------------------------------------------------------------------------
package tsdl_pkg;

    // Q1.15 unity and rounding half
    localparam logic [15:0] ONE_Q15  = 16'd32768;
    localparam logic [30:0] HALF_Q15 = 31'd16384;

    // Quotient bits delivered by the divider (factors stay below 1.0)
    localparam int unsigned DIV_STEPS = 15;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Shared multiplier operand widths
    localparam int unsigned MUL_A_W = 31;
    localparam int unsigned MUL_B_W = 16;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    // Register map, word index = paddr[4:2]
    localparam int unsigned PADDR_W = 5;
    localparam logic [2:0] REG_SLIP_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_SLIP_STRENGTH  = 3'd1;
    localparam logic [2:0] REG_DROP_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_DROP_STRENGTH  = 3'd3;
    localparam logic [2:0] REG_DECAY_ALPHA    = 3'd4;

    // Reset values of the configuration registers
    localparam logic [14:0] SLIP_THRESHOLD_RST = 15'd1280;
    localparam logic [15:0] SLIP_STRENGTH_RST  = 16'd32768;
    localparam logic [14:0] DROP_THRESHOLD_RST = 15'd2560;
    localparam logic [15:0] DROP_STRENGTH_RST  = 16'd32768;
    localparam logic [15:0] DECAY_ALPHA_RST    = 16'd328;

    typedef struct packed {
        logic signed [15:0] wheel_acc;
        logic signed [15:0] board_acc;
        logic        [14:0] accel_magnitude;
    } sample_t;

    typedef struct packed {
        logic [15:0] slip_level;
        logic [15:0] drop_level;
        logic [15:0] current_gain;
        logic [15:0] release_level;
    } result_t;

    // Sequencer to divider
    typedef struct packed {
        logic        start;
        logic [15:0] rem_init;
        logic [15:0] divisor;
    } div_ctrl_t;

    // Divider to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Clamp a Q1.15 value at 1.0
    function automatic logic [15:0] sat_one(input logic [15:0] v);
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

endpackage

// ----- hw/rtl/tsdl_div.sv -----
// ---------------------------------------------------------------------------
// tsdl_div: iterative restoring divider
// Produces floor((rem_init << 15) / divisor), one quotient bit per cycle,
// for rem_init < divisor.
// ---------------------------------------------------------------------------
module tsdl_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tsdl_pkg::div_ctrl_t ctrl,
    output tsdl_pkg::div_stat_t stat,
    output logic [14:0]        quotient
);
    import tsdl_pkg::*;

    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          divisor_reg, divisor_next;
    logic [14:0]          quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [16:0] shifted;
    logic [16:0] trial;
    logic        fits;

    // One shared compare-and-subtract per cycle
    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, divisor_reg};
    assign fits    = (shifted >= {1'b0, divisor_reg});

    always_comb
    begin
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (ctrl.start)
        begin
            rem_next     = ctrl.rem_init;
            divisor_next = ctrl.divisor;
            quo_next     = '0;
            cnt_next     = DIV_CNT_W'(DIV_STEPS);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[15:0] : shifted[15:0];
            quo_next = {quo_reg[13:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        quo_reg     <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- hw/rtl/tsdl_mul.sv -----
// ---------------------------------------------------------------------------
// tsdl_mul: shared registered multiplier
// Unsigned 31 x 16 product, loaded when issue is high, held otherwise.
// ---------------------------------------------------------------------------
module tsdl_mul (
    input  logic                          clk,
    input  logic                          issue,
    input  logic [tsdl_pkg::MUL_A_W-1:0]  a,
    input  logic [tsdl_pkg::MUL_B_W-1:0]  b,
    output logic [tsdl_pkg::MUL_P_W-1:0]  p
);
    import tsdl_pkg::*;

    logic [MUL_P_W-1:0] p_reg, p_next;

    always_comb
    begin
        p_next = p_reg;
        if (issue)
        begin
            p_next = MUL_P_W'(a) * MUL_P_W'(b);
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ----- hw/rtl/traction_slip_drop_limiter.sv -----
// ---------------------------------------------------------------------------
// traction_slip_drop_limiter: slip and free-fall current limiter
// Maps wheel/board acceleration mismatch and acceleration magnitude to
// Q1.15 slip and drop factors, a combined current gain and a soft-release
// level, using one iterative divider and one shared multiplier.
// ---------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one control
//   sample; a transfer happens when valid is high and stall is low.
//   result channel (result_valid / result_stall / result) returns exactly one
//   result per sample, in order.
//   Each factor that needs a division runs 15 steps plus handoff on the
//   shared divider; after that, five multiplications go one per cycle
//   through the shared multiplier.
//   The user must write configuration over the APB port only while the
//   block is idle; the block itself does not enforce this.
//   sample_stall is high from the cycle after a transfer until the result is
//   loaded into the output register, so one sample is in flight at a time.
//   The output register parts the two channels: a new sample is taken while
//   a finished result still waits. A stalled result holds its value; the
//   next result waits in the sequencer until the output register frees up.
//   Reset returns the configuration registers to their defaults and clears
//   the soft-release level; no clearing pass is needed.
// ---------------------------------------------------------------------------
module traction_slip_drop_limiter (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample channel
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  tsdl_pkg::sample_t             sample,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output tsdl_pkg::result_t             result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsdl_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tsdl_pkg::*;

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SLIP = 4'd1;
    localparam logic [3:0] ST_SDIV = 4'd2;
    localparam logic [3:0] ST_DROP = 4'd3;
    localparam logic [3:0] ST_RDIV = 4'd4;
    localparam logic [3:0] ST_M1   = 4'd5;
    localparam logic [3:0] ST_M2   = 4'd6;
    localparam logic [3:0] ST_M3   = 4'd7;
    localparam logic [3:0] ST_M4   = 4'd8;
    localparam logic [3:0] ST_M5   = 4'd9;
    localparam logic [3:0] ST_M6   = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic [14:0] slip_threshold_reg, slip_threshold_next;
    logic [15:0] slip_strength_reg,  slip_strength_next;
    logic [14:0] drop_threshold_reg, drop_threshold_next;
    logic [15:0] drop_strength_reg,  drop_strength_next;
    logic [15:0] decay_alpha_reg,    decay_alpha_next;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    // Decode the write; indexes past the map are dropped
    always_comb
    begin
        slip_threshold_next = slip_threshold_reg;
        slip_strength_next  = slip_strength_reg;
        drop_threshold_next = drop_threshold_reg;
        drop_strength_next  = drop_strength_reg;
        decay_alpha_next    = decay_alpha_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SLIP_THRESHOLD: slip_threshold_next = pwdata[14:0];
                REG_SLIP_STRENGTH:  slip_strength_next  = pwdata[15:0];
                REG_DROP_THRESHOLD: drop_threshold_next = pwdata[14:0];
                REG_DROP_STRENGTH:  drop_strength_next  = pwdata[15:0];
                REG_DECAY_ALPHA:    decay_alpha_next    = pwdata[15:0];
                default:            ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (cfg_index)
            REG_SLIP_THRESHOLD: prdata = {17'd0, slip_threshold_reg};
            REG_SLIP_STRENGTH:  prdata = {16'd0, slip_strength_reg};
            REG_DROP_THRESHOLD: prdata = {17'd0, drop_threshold_reg};
            REG_DROP_STRENGTH:  prdata = {16'd0, drop_strength_reg};
            REG_DECAY_ALPHA:    prdata = {16'd0, decay_alpha_reg};
            default:            prdata = '0;
        endcase
    end

    // -----------------------------------------------------------------------
    // Shared units
    // -----------------------------------------------------------------------
    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;
    logic [14:0]        div_quotient;

    logic               mul_issue;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    tsdl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    tsdl_mul u_mul (
        .clk   (clk),
        .issue (mul_issue),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p)
    );

    // -----------------------------------------------------------------------
    // Sequencer and working registers
    // -----------------------------------------------------------------------
    logic [3:0]  state_reg, state_next;
    logic [15:0] soft_release_reg, soft_release_next;
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg, result_next;

    logic [16:0] absd_reg, absd_next;
    logic [15:0] mag2_reg, mag2_next;
    logic [15:0] s_reg, s_next;
    logic [15:0] d_reg, d_next;
    logic [15:0] slip_scale_reg, slip_scale_next;
    logic [15:0] drop_scale_reg, drop_scale_next;
    logic [15:0] gain_reg, gain_next;

    logic        sample_xfer;
    logic        result_free;
    logic [16:0] diff;
    logic [16:0] slip_excess;
    logic [16:0] drop_excess;
    logic [15:0] drop_span;
    logic [15:0] s_loss;
    logic [15:0] d_loss;
    logic [15:0] release_gap;
    logic [30:0] release_sum;

    assign sample_stall = (state_reg != ST_IDLE);
    assign sample_xfer  = sample_valid && !sample_stall;
    assign result_free  = !result_valid_reg || !result_stall;

    assign diff        = {sample.wheel_acc[15], sample.wheel_acc}
                       - {sample.board_acc[15], sample.board_acc};
    assign slip_excess = absd_reg - {2'b00, slip_threshold_reg};
    assign drop_excess = {1'b0, mag2_reg} - {2'b00, drop_threshold_reg};
    assign drop_span   = {drop_threshold_reg, 1'b0};
    assign s_loss      = ONE_Q15 - sat_one(slip_strength_reg);
    assign d_loss      = ONE_Q15 - sat_one(drop_strength_reg);
    assign release_gap = soft_release_reg - s_reg;
    assign release_sum = mul_p[30:0] + HALF_Q15;

    always_comb
    begin
        state_next        = state_reg;
        soft_release_next = soft_release_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        absd_next         = absd_reg;
        mag2_next         = mag2_reg;
        s_next            = s_reg;
        d_next            = d_reg;
        slip_scale_next   = slip_scale_reg;
        drop_scale_next   = drop_scale_reg;
        gain_next         = gain_reg;
        div_ctrl          = '0;
        mul_issue         = 1'b0;
        mul_a             = '0;
        mul_b             = '0;

        // Retire a taken result
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    absd_next  = diff[16] ? (17'd0 - diff) : diff;
                    mag2_next  = {sample.accel_magnitude, 1'b0};
                    state_next = ST_SLIP;
                end
            end
            ST_SLIP:
            begin
                // Zero threshold or difference at twice it: full slip
                state_next = ST_DROP;
                if (slip_threshold_reg == '0)
                begin
                    s_next = ONE_Q15;
                end
                else if (absd_reg <= {2'b00, slip_threshold_reg})
                begin
                    s_next = '0;
                end
                else if (slip_excess >= {2'b00, slip_threshold_reg})
                begin
                    s_next = ONE_Q15;
                end
                else
                begin
                    div_ctrl.start    = 1'b1;
                    div_ctrl.rem_init = slip_excess[15:0];
                    div_ctrl.divisor  = {1'b0, slip_threshold_reg};
                    state_next        = ST_SDIV;
                end
            end
            ST_SDIV:
            begin
                if (div_stat.done)
                begin
                    s_next     = {1'b0, div_quotient};
                    state_next = ST_DROP;
                end
            end
            ST_DROP:
            begin
                // Zero threshold: no drop window, drop factor stays zero
                state_next = ST_M1;
                if (drop_threshold_reg == '0)
                begin
                    d_next = '0;
                end
                else if (mag2_reg <= {1'b0, drop_threshold_reg})
                begin
                    d_next = ONE_Q15;
                end
                else if (drop_excess >= {1'b0, drop_span})
                begin
                    d_next = '0;
                end
                else
                begin
                    div_ctrl.start    = 1'b1;
                    div_ctrl.rem_init = drop_excess[15:0];
                    div_ctrl.divisor  = drop_span;
                    state_next        = ST_RDIV;
                end
            end
            ST_RDIV:
            begin
                if (div_stat.done)
                begin
                    d_next     = ONE_Q15 - {1'b0, div_quotient};
                    state_next = ST_M1;
                end
            end
            ST_M1:
            begin
                mul_issue  = 1'b1;
                mul_a      = MUL_A_W'(s_loss);
                mul_b      = s_reg;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                slip_scale_next = ONE_Q15 - mul_p[30:15];
                mul_issue       = 1'b1;
                mul_a           = MUL_A_W'(d_loss);
                mul_b           = d_reg;
                state_next      = ST_M3;
            end
            ST_M3:
            begin
                // Chain the drop loss through the slip factor
                mul_issue  = 1'b1;
                mul_a      = mul_p[MUL_A_W-1:0];
                mul_b      = s_reg;
                state_next = ST_M4;
            end
            ST_M4:
            begin
                drop_scale_next = ONE_Q15 - mul_p[45:30];
                mul_issue       = 1'b1;
                mul_a           = MUL_A_W'(release_gap);
                mul_b           = sat_one(decay_alpha_reg);
                state_next      = ST_M5;
            end
            ST_M5:
            begin
                // Jump up to the slip factor, else decay toward it
                if (s_reg > soft_release_reg)
                begin
                    soft_release_next = s_reg;
                end
                else
                begin
                    soft_release_next = soft_release_reg - release_sum[30:15];
                end
                mul_issue  = 1'b1;
                mul_a      = MUL_A_W'(slip_scale_reg);
                mul_b      = drop_scale_reg;
                state_next = ST_M6;
            end
            ST_M6:
            begin
                gain_next  = mul_p[30:15];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register frees up
                if (result_free)
                begin
                    result_next.slip_level    = s_reg;
                    result_next.drop_level    = d_reg;
                    result_next.current_gain  = gain_reg;
                    result_next.release_level = soft_release_reg;
                    result_valid_next         = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            soft_release_reg   <= '0;
            result_valid_reg   <= 1'b0;
            slip_threshold_reg <= SLIP_THRESHOLD_RST;
            slip_strength_reg  <= SLIP_STRENGTH_RST;
            drop_threshold_reg <= DROP_THRESHOLD_RST;
            drop_strength_reg  <= DROP_STRENGTH_RST;
            decay_alpha_reg    <= DECAY_ALPHA_RST;
        end
        else
        begin
            state_reg          <= state_next;
            soft_release_reg   <= soft_release_next;
            result_valid_reg   <= result_valid_next;
            slip_threshold_reg <= slip_threshold_next;
            slip_strength_reg  <= slip_strength_next;
            drop_threshold_reg <= drop_threshold_next;
            drop_strength_reg  <= drop_strength_next;
            decay_alpha_reg    <= decay_alpha_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        result_reg     <= result_next;
        absd_reg       <= absd_next;
        mag2_reg       <= mag2_next;
        s_reg          <= s_next;
        d_reg          <= d_next;
        slip_scale_reg <= slip_scale_next;
        drop_scale_reg <= drop_scale_next;
        gain_reg       <= gain_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- hw/rtl/tsdl_checker.sv -----
// ---------------------------------------------------------------------------
// tsdl_checker: port-level checks of the traction slip/drop limiter
// Watches the sample and result channels and is bound to the top level.
// ---------------------------------------------------------------------------
module tsdl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_stall,
    input tsdl_pkg::result_t result,
    input logic              result_valid,
    input logic              result_stall
);
    import tsdl_pkg::*;

    // One sample in flight: busy right after a transfer
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("sample taken while a sample is in flight");

    // A new result only comes out of work on a sample
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
        else $error("result appeared with no sample in flight");

    // Release never sits below the slip factor it follows
    a_release_above_slip: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.release_level >= result.slip_level)
        else $error("release level below slip level");

    // All Q1.15 outputs stay within 0..1.0
    a_levels_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.slip_level <= ONE_Q15
                      && result.drop_level <= ONE_Q15
                      && result.current_gain <= ONE_Q15
                      && result.release_level <= ONE_Q15)
        else $error("output level above 1.0");

    // A stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule

bind traction_slip_drop_limiter tsdl_checker u_tsdl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
);

// ----- verif/tb_traction_slip_drop_limiter.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_traction_slip_drop_limiter: self-checking bench for the slip/drop limiter
// Streams control samples through the block under several register settings,
// extremes included, and checks every result field against a fixed-point
// model of the slip, drop, gain and soft-release arithmetic. Both channels
// stall and idle at random; one phase holds the result side off for a long
// stretch so that the block backs up into its sample channel.
// ---------------------------------------------------------------------------
module tb_traction_slip_drop_limiter;

    import tsdl_pkg::*;

    localparam int unsigned Q15_ONE = ONE_Q15;

    // index with no register behind it; writes there must change nothing
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    localparam int unsigned PHASE_COUNT  = 12;
    localparam int unsigned PHASE_ITEMS  = 165;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned SETTLE_TICKS = 60;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic    sample_valid = 1'b0;
    logic    sample_stall;
    sample_t sample       = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    // shadow copy of the configuration and of the soft-release level
    int unsigned cfg_slip_knee = SLIP_THRESHOLD_RST;
    int unsigned cfg_slip_str  = SLIP_STRENGTH_RST;
    int unsigned cfg_drop_knee = DROP_THRESHOLD_RST;
    int unsigned cfg_drop_str  = DROP_STRENGTH_RST;
    int unsigned cfg_alpha     = DECAY_ALPHA_RST;
    int unsigned release_q     = 0;

    sample_t pending_samples[$];
    result_t expected_results[$];

    int unsigned error_count  = 0;
    int unsigned results_seen = 0;

    // idling control, set per phase by the stimulus process
    bit          send_idle_on = 1'b0;
    bit          recv_idle_on = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned recv_burst   = 0;

    // long receiver hold-off, requested by stimulus, counted below
    int unsigned hold_requests    = 0;
    int unsigned holds_served     = 0;
    int unsigned hold_cycles_left = 0;

    traction_slip_drop_limiter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // -----------------------------------------------------------------------
    // Fixed-point model
    // -----------------------------------------------------------------------

    // clamp a Q1.15 weight at 1.0
    function automatic int unsigned clamp_unity(input int unsigned v);
        return (v > Q15_ONE) ? Q15_ONE : v;
    endfunction

    // map x from [lo, lo + span] onto [0, 1.0] in Q1.15, clamped at both ends
    function automatic int unsigned ramp_q15(input int unsigned x, input int unsigned lo,
                                             input int unsigned span);
        longint unsigned scaled;
        if (span == 0)
            return (x >= lo) ? Q15_ONE : 0;
        if (x <= lo)
            return 0;
        if (x - lo >= span)
            return Q15_ONE;
        scaled = longint'(x - lo) << 15;
        return int'(scaled / span);
    endfunction

    // result of one sample; advances the soft-release level
    function automatic result_t limit_sample(input sample_t s);
        int              diff;
        int unsigned     absd;
        int unsigned     slip;
        int unsigned     drop;
        int unsigned     s_loss;
        int unsigned     d_loss;
        int unsigned     slip_scale;
        int unsigned     drop_scale;
        longint unsigned drop_cut;
        longint unsigned step;
        result_t         r;
        diff = int'(s.wheel_acc) - int'(s.board_acc);
        absd = (diff < 0) ? -diff : diff;
        slip = ramp_q15(absd, cfg_slip_knee, cfg_slip_knee);
        drop = Q15_ONE - ramp_q15(2 * s.accel_magnitude, cfg_drop_knee, 2 * cfg_drop_knee);

        s_loss     = Q15_ONE - clamp_unity(cfg_slip_str);
        d_loss     = Q15_ONE - clamp_unity(cfg_drop_str);
        slip_scale = Q15_ONE - ((s_loss * slip) >> 15);
        // drop term is weighted by slip as well
        drop_cut   = (longint'(d_loss) * drop * slip) >> 30;
        drop_scale = Q15_ONE - int'(drop_cut);

        // jump up to the slip factor, otherwise decay toward it with rounding
        if (slip > release_q) begin
            release_q = slip;
        end
        else begin
            step      = (longint'(release_q - slip) * clamp_unity(cfg_alpha) + 16384) >> 15;
            release_q = release_q - int'(step);
        end

        r.slip_level    = slip[15:0];
        r.drop_level    = drop[15:0];
        r.current_gain  = 16'((slip_scale * drop_scale) >> 15);
        r.release_level = release_q[15:0];
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Sample driver: take the next pending sample whenever the slot is free,
    // hold the payload while stalled, and insert random idle bursts.
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
            send_gap     <= 0;
        end
        else
        begin
            // predict at the transfer, in order of acceptance
            if (sample_valid && !sample_stall)
                expected_results.push_back(limit_sample(sample));

            if (!sample_valid || !sample_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap     <= send_gap - 1;
                    sample_valid <= 1'b0;
                end
                else if (send_idle_on && $urandom_range(0, 5) == 0)
                begin
                    // start a random idle burst, this slot included
                    send_gap     <= $urandom_range(0, 15);
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    sample_valid <= 1'b1;
                    sample       <= pending_samples.pop_front();
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Long hold-off of the result side, counted in cycles here
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles_left <= 0;
            holds_served     <= 0;
        end
        else if (hold_cycles_left != 0)
        begin
            hold_cycles_left <= hold_cycles_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served     <= holds_served + 1;
            hold_cycles_left <= LONG_HOLD;
        end
    end

    // -----------------------------------------------------------------------
    // Result monitor: check each transfer against the oldest expectation
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string field, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_seen, field, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            recv_burst   <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("slip_level",    result.slip_level,    want.slip_level);
                    check_field("drop_level",    result.drop_level,    want.drop_level);
                    check_field("current_gain",  result.current_gain,  want.current_gain);
                    check_field("release_level", result.release_level, want.release_level);
                end
                results_seen++;
            end

            if (hold_cycles_left != 0)
            begin
                result_stall <= 1'b1;
            end
            else if (recv_burst != 0)
            begin
                recv_burst   <= recv_burst - 1;
                result_stall <= 1'b1;
            end
            else if (recv_idle_on && $urandom_range(0, 5) == 0)
            begin
                recv_burst   <= $urandom_range(0, 15);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------

    // APB register write in setup and access phases; update the shadow copy to match
    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_SLIP_THRESHOLD: cfg_slip_knee = value[14:0];
            REG_SLIP_STRENGTH:  cfg_slip_str  = value[15:0];
            REG_DROP_THRESHOLD: cfg_drop_knee = value[14:0];
            REG_DROP_STRENGTH:  cfg_drop_str  = value[15:0];
            REG_DECAY_ALPHA:    cfg_alpha     = value[15:0];
            default: ;
        endcase
    endtask

    // write every register, plus a stray write that must be ignored
    task automatic load_config(input int unsigned slip_knee, input int unsigned slip_str,
                               input int unsigned drop_knee, input int unsigned drop_str,
                               input int unsigned alpha);
        write_register(REG_SLIP_THRESHOLD, slip_knee);
        write_register(REG_SLIP_STRENGTH,  slip_str);
        write_register(REG_DROP_THRESHOLD, drop_knee);
        write_register(REG_DROP_STRENGTH,  drop_str);
        write_register(REG_DECAY_ALPHA,    alpha);
        write_register(REG_UNMAPPED,       $urandom);
    endtask

    task automatic queue_sample(input int wheel, input int board, input int unsigned mag);
        sample_t s;
        s.wheel_acc       = 16'(wheel);
        s.board_acc       = 16'(board);
        s.accel_magnitude = 15'(mag);
        pending_samples.push_back(s);
    endtask

    // mostly samples placed around the current thresholds, some pure noise
    task automatic queue_random_sample();
        int unsigned absd;
        int unsigned mag_top;
        int          board;
        if ($urandom_range(0, 4) == 0)
        begin
            queue_sample($urandom, $urandom, $urandom);
        end
        else
        begin
            absd = $urandom_range(0, 3 * cfg_slip_knee + 2);
            if (absd > 65535)
                absd = 65535;
            board   = -32768 + int'($urandom_range(0, 65535 - absd));
            mag_top = (3 * cfg_drop_knee + 3) / 2;
            if (mag_top > 32767)
                mag_top = 32767;
            if ($urandom_range(0, 1))
                queue_sample(board + int'(absd), board, $urandom_range(0, mag_top));
            else
                queue_sample(board, board + int'(absd), $urandom_range(0, mag_top));
        end
    endtask

    // thresholds: zero, one, full scale, anywhere, or a value that keeps ramps reachable
    function automatic int unsigned pick_threshold();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return 32767;
            3:       return $urandom_range(0, 32767);
            default: return $urandom_range(2, 6000);
        endcase
    endfunction

    // strengths and alpha: zero, unity, above unity, or anywhere
    function automatic int unsigned pick_weight();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return Q15_ONE;
            2:       return 65535;
            3:       return $urandom_range(0, 65535);
            default: return $urandom_range(0, Q15_ONE);
        endcase
    endfunction

    // wait at a falling edge until every sample went out and every result came
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed samples under the reset configuration (T = 1280, U = 2560)
        queue_sample(0, 0, 0);
        queue_sample(32767, -32768, 32767);     // widest difference, largest magnitude
        queue_sample(-32768, 32767, 0);
        queue_sample(1280, 0, 1280);            // slip just at T, magnitude at U
        queue_sample(0, 1281, 1281);            // one past both lower edges
        queue_sample(2560, 0, 3840);            // full slip at 2T, no drop at 3U
        queue_sample(0, 2559, 3839);            // one short of both upper edges
        queue_sample(-1000, 1000, 2000);
        queue_sample(1920, 0, 0);               // half slip, full drop
        queue_sample(3000, -200, 640);
        queue_sample(0, 0, 1000);               // release decays from here
        queue_sample(0, 0, 1000);
        queue_sample(0, 0, 1000);
        queue_sample(16, -16, 1279);
        queue_sample(-32768, -32768, 16384);
        queue_sample(32767, 32767, 100);
        wait_drained();

        // zero thresholds, strongest limits, full-weight decay
        load_config(0, 0, 0, 0, Q15_ONE);
        for (int i = 0; i < 8; i++)
            queue_sample($urandom, $urandom, $urandom);
        wait_drained();

        for (int unsigned phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       load_config(32767, 65535, 32767, 65535, 65535);
                1:       load_config(1, 0, 1, 0, 0);
                2:       load_config(1280, 16384, 2560, 8192, 1);
                default: load_config(pick_threshold(), pick_weight(), pick_threshold(),
                                     pick_weight(), pick_weight());
            endcase

            // last phase runs back to back; others idle in most cases
            send_idle_on = (phase != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
            recv_idle_on = (phase != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);

            // back the block up into the sample channel while samples keep coming
            if (phase == 2)
                hold_requests++;

            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
                queue_random_sample();

            // hold the sender until the phase has fully drained
            wait_drained();
        end

        repeat (SETTLE_TICKS) @(posedge clk);
        if (error_count == 0)
            $display("traction_slip_drop_limiter test passed");
        else
            $display("traction_slip_drop_limiter test failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #15_000_000;
        $display("traction_slip_drop_limiter test failed");
        $finish;
    end

endmodule
